@@ hw/rtl/speck64_128_encrypt_top_defines.svh @@
// assertion macros for the speck 64/128 encryption engine
// used by the top level; needs a clock named clk and reset named arst_n in scope
`ifndef SPECK64_128_ENCRYPT_TOP_DEFINES_SVH
`define SPECK64_128_ENCRYPT_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SPK_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define SPK_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/speck_pkg.sv @@
// shared types, constants and round functions for the speck 64/128 engine
// no dependencies; imported by every module of the block
package speck_pkg;

	localparam int WORD_W     = 32;
	localparam int KEY_REGS   = 4;
	localparam int ROUNDS_DEF = 27;

	typedef logic [WORD_W-1:0] word_t;

	// key register indexes on the configuration port
	typedef enum logic [1:0] {
		KEY_K0 = 2'd0,
		KEY_L0 = 2'd1,
		KEY_L1 = 2'd2,
		KEY_L2 = 2'd3
	} key_idx_t;

	typedef struct packed {
		logic [WORD_W-1:0] plain_high;
		logic [WORD_W-1:0] plain_low;
	} plain_t;

	typedef struct packed {
		logic [WORD_W-1:0] cipher_high;
		logic [WORD_W-1:0] cipher_low;
	} cipher_t;

	// working x/y pair of one round
	typedef struct packed {
		word_t x;
		word_t y;
	} blk_t;

	function automatic word_t ror8(input word_t v);
		return {v[7:0], v[WORD_W-1:8]};
	endfunction

	function automatic word_t rol3(input word_t v);
		return {v[WORD_W-4:0], v[WORD_W-1:WORD_W-3]};
	endfunction

	// one round: x -> (ror8(x) + y) ^ k, y -> rol3(y) ^ new x
	function automatic blk_t speck_mix(input word_t x, input word_t y, input word_t k);
		blk_t  r;
		word_t nx;
		nx  = word_t'(ror8(x) + y) ^ k;
		r.x = nx;
		r.y = rol3(y) ^ nx;
		return r;
	endfunction

endpackage

@@ hw/rtl/speck64_128_encrypt_top.sv @@
// top level of the speck 64/128 encryption engine: round pipeline and output skid
// depends on speck_pkg, speck_stage, speck_ksched and the assertion macro header
//
//  channel   direction  handshake              payload
//  plain     in         plain_valid/stall      plain_t  (plain_high, plain_low)
//  cipher    out        cipher_valid/stall     cipher_t (cipher_high, cipher_low)
//  cfg       in         cfg_valid/cfg_ready    cfg_index (key_idx_t), cfg_data
//
// one block enters per cycle while plain_stall is low; one round per pipeline stage
// after reset and after every key write the schedule expands one round key per cycle
// in the key unit, with plain_stall held high
// a stalled result moves into a one-item skid register; plain_stall rises the cycle after
`include "speck64_128_encrypt_top_defines.svh"

module speck64_128_encrypt_top #(
	parameter int ROUNDS = speck_pkg::ROUNDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                plain_valid,
	output logic                plain_stall,
	input  speck_pkg::plain_t   plain,
	output logic                cipher_valid,
	input  logic                cipher_stall,
	output speck_pkg::cipher_t  cipher,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  speck_pkg::key_idx_t cfg_index,
	input  speck_pkg::word_t    cfg_data
);
	import speck_pkg::*;

	logic [ROUNDS-1:0][WORD_W-1:0] sub_keys;
	logic                          ks_busy;
	logic                          cfg_we;
	logic                          accept;
	logic                          pipe_en;
	logic [ROUNDS:0]               vld;
	blk_t                          blk [ROUNDS+1];
	logic                          skid_full_q;
	blk_t                          skid_q;
	blk_t                          out_blk;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	speck_ksched #(
		.ROUNDS(ROUNDS)
	) u_ksched (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.busy       (ks_busy),
		.sub_keys   (sub_keys)
	);

	assign pipe_en     = !skid_full_q;
	assign plain_stall = ks_busy || skid_full_q;
	assign accept      = plain_valid && !plain_stall;

	assign vld[0]   = accept;
	assign blk[0].x = plain.plain_high;
	assign blk[0].y = plain.plain_low;

	for (genvar g = 0; g < ROUNDS; g++) begin : g_round
		speck_stage u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (pipe_en),
			.valid_in  (vld[g]),
			.blk_in    (blk[g]),
			.sub_key   (sub_keys[g]),
			.valid     (vld[g+1]),
			.blk       (blk[g+1])
		);
	end

	// skid catches the last stage when the consumer stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			skid_full_q <= cipher_stall;
		end else begin
			skid_full_q <= vld[ROUNDS] && cipher_stall;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_full_q && vld[ROUNDS] && cipher_stall) begin
			skid_q <= blk[ROUNDS];
		end
	end

	assign out_blk            = skid_full_q ? skid_q : blk[ROUNDS];
	assign cipher_valid       = skid_full_q || vld[ROUNDS];
	assign cipher.cipher_high = out_blk.x;
	assign cipher.cipher_low  = out_blk.y;

	`SPK_ASSERT_NOW(a_busy_stalls, ks_busy, plain_stall, "item accepted during key expansion")
	`SPK_ASSERT_NEXT(a_write_expands, cfg_we, ks_busy, "key write did not start expansion")
	`SPK_ASSERT_NEXT(a_skid_holds, skid_full_q && cipher_stall, skid_full_q && $stable(skid_q), "stalled skid item lost or changed")
	`SPK_ASSERT_NEXT(a_skid_drains, skid_full_q && !cipher_stall, !skid_full_q, "skid item delivered twice")

endmodule

@@ hw/rtl/speck_round.sv @@
// one encryption round as a single pipeline stage
// depends on speck_pkg
module speck_stage (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    valid_in,
	input  speck_pkg::blk_t         blk_in,
	input  speck_pkg::word_t        sub_key,
	output logic                    valid,
	output speck_pkg::blk_t         blk
);
	import speck_pkg::*;

	logic vld_s1;
	blk_t blk_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_in) begin
			blk_s1 <= speck_mix(blk_in.x, blk_in.y, sub_key);
		end
	end

	assign valid = vld_s1;
	assign blk   = blk_s1;

endmodule

@@ hw/rtl/speck_ksched.sv @@
// key registers and round key expansion, one round key per cycle
// depends on speck_pkg
module speck_ksched #(
	parameter int ROUNDS = speck_pkg::ROUNDS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_we,
	input  speck_pkg::key_idx_t                      cfg_index,
	input  speck_pkg::word_t                         cfg_data,
	output logic                                     busy,
	output logic [ROUNDS-1:0][speck_pkg::WORD_W-1:0] sub_keys
);
	import speck_pkg::*;

	localparam int STORE_D = ROUNDS - 1;
	localparam int RW      = (STORE_D > 1) ? $clog2(STORE_D) : 1;

	logic [KEY_REGS-1:0][WORD_W-1:0] key_q;
	logic [KEY_REGS-1:0][WORD_W-1:0] key_d;
	word_t                           k_q;
	word_t                           lw_q [3];
	logic [RW-1:0]                   r_q;
	logic                            busy_q;
	word_t                           store_q [STORE_D];
	blk_t                            mix;

	always_comb begin
		key_d = key_q;
		unique case (cfg_index)
			KEY_K0:  key_d[0] = cfg_data;
			KEY_L0:  key_d[1] = cfg_data;
			KEY_L1:  key_d[2] = cfg_data;
			KEY_L2:  key_d[3] = cfg_data;
			default: key_d    = key_q;
		endcase
	end

	// the l word in use always sits at the head of the three-word queue
	assign mix = speck_mix(lw_q[0], k_q, WORD_W'(r_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q   <= '0;
			k_q     <= '0;
			lw_q[0] <= '0;
			lw_q[1] <= '0;
			lw_q[2] <= '0;
			r_q     <= '0;
			busy_q  <= 1'b1;
		end else if (cfg_we) begin
			key_q   <= key_d;
			k_q     <= key_d[0];
			lw_q[0] <= key_d[1];
			lw_q[1] <= key_d[2];
			lw_q[2] <= key_d[3];
			r_q     <= '0;
			busy_q  <= 1'b1;
		end else if (busy_q) begin
			k_q     <= mix.y;
			lw_q[0] <= lw_q[1];
			lw_q[1] <= lw_q[2];
			lw_q[2] <= mix.x;
			r_q     <= r_q + RW'(1);
			busy_q  <= (r_q != RW'(STORE_D - 1));
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && !cfg_we) begin
			store_q[r_q] <= mix.y;
		end
	end

	// round key zero is the first key word itself
	always_comb begin
		sub_keys[0] = key_q[0];
		for (int i = 1; i < ROUNDS; i++) begin
			sub_keys[i] = store_q[i-1];
		end
	end

	assign busy = busy_q;

endmodule
